// File: rtl/rv32im_instruction_execute_macros.svh
// Assertion macros shared by the execute block modules
`ifndef RV32IM_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32IM_INSTRUCTION_EXECUTE_MACROS_SVH
// implication checked on every clock unless reset is asserted
`define RVX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RVX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/rvx_pkg.sv
// Package: shared types and constants of the execute block
`timescale 1ns / 1ps
`default_nettype none
package rvx_pkg;
  localparam logic [1:0] KIND_EXEC = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_JUMP = 2'd3;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_BAD_OP = 4'd1;
  localparam logic [3:0] ST_BAD_FN = 4'd2;
  localparam logic [3:0] ST_PC_OUT = 4'd3;
  localparam logic [3:0] ST_BEYOND = 4'd4;
  localparam logic [3:0] ST_TEXT = 4'd5;
  localparam logic [3:0] ST_NOT_LOADED = 4'd6;
  localparam logic [3:0] ST_BAD_TARGET = 4'd7;
  localparam logic [3:0] ST_SEQ = 4'd8;

  localparam logic [2:0] CFG_MEM_BYTES = 3'd0;
  localparam logic [2:0] CFG_TEXT_START = 3'd1;
  localparam logic [2:0] CFG_TEXT_END = 3'd2;
  localparam logic [2:0] CFG_START_PC = 3'd3;
  localparam logic [2:0] CFG_START_STACK = 3'd4;

  localparam logic [6:0] OP_REG = 7'h33;
  localparam logic [6:0] OP_IMM = 7'h13;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_AUIPC = 7'h17;
  localparam logic [6:0] OP_JAL = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_FENCE = 7'h0F;

  // result item
  typedef struct packed {
    logic [31:0] writeback_value;
    logic [4:0]  writeback_register;
    logic        writeback_valid;
    logic [31:0] store_data;
    logic [1:0]  access_size;
    logic [31:0] mem_address;
    logic        mem_write;
    logic        mem_read;
    logic [31:0] next_pc;
    logic [3:0]  status;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture request and read operands
    logic decode;     // compute decode and non-divide results
    logic div_start;  // start iterative divider
    logic div_step;   // one divider step
    logic commit;     // update state and form result
    logic clear_step; // one step of the restart clearing sweep
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic clear_done;
    logic is_restart;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/rv32im_instruction_execute.sv
// Top level: RV32IM execute block with streaming request and result channels
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid/in_tready    | tuser kind, tdata instr/load/target
//  out     | out | out_tvalid/out_tready  | tdata result fields
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// A request's result is registered at commit and then offered on the out
// channel; requests do not overlap. M divides and remainders use the shared
// divider, one quotient bit per cycle. Restart sweeps the register file one
// entry per cycle. Synchronous active-low reset. The next request is taken
// in the cycle its result leaves.
`timescale 1ns / 1ps
`default_nettype none
module rv32im_instruction_execute
  import rvx_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,  // instruction, load_value, target_pc
  input  wire logic [1:0]   in_tuser,  // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, next_pc, mem_read, mem_write, mem_address, access_size,
  // store_data, writeback_valid, writeback_register, writeback_value
  output logic [143:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  logic [31:0] mem_bytes_r, text_start_r, text_end_r, start_pc_r, start_stack_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= '0; text_start_r <= '0; text_end_r <= '0;
      start_pc_r <= '0; start_stack_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEM_BYTES: mem_bytes_r <= cfg_data;
        CFG_TEXT_START: text_start_r <= cfg_data;
        CFG_TEXT_END: text_end_r <= cfg_data;
        CFG_START_PC: start_pc_r <= cfg_data;
        CFG_START_STACK: start_stack_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rvx_control u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .stat(stat)
  );

  rvx_datapath #(.REGISTER_COUNT(REGISTER_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .kind(in_tuser),
    .instruction(in_tdata[31:0]), .load_value(in_tdata[63:32]),
    .target_pc(in_tdata[95:64]), .memory_bytes(mem_bytes_r),
    .text_start(text_start_r), .text_end(text_end_r), .start_pc(start_pc_r),
    .start_stack(start_stack_r), .result(res)
  );

  assign out_tdata = {2'b00, res.writeback_value, res.writeback_register,
                      res.writeback_valid, res.store_data, res.access_size,
                      res.mem_address, res.mem_write, res.mem_read,
                      res.next_pc, res.status};
endmodule
`default_nettype wire

// File: rtl/rvx_datapath.sv
// Datapath: register file, pc, decode, ALU, multiplier and divider
`timescale 1ns / 1ps
`default_nettype none
module rvx_datapath
  import rvx_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] load_value,
  input  wire logic [31:0] target_pc,
  input  wire logic [31:0] memory_bytes,
  input  wire logic [31:0] text_start,
  input  wire logic [31:0] text_end,
  input  wire logic [31:0] start_pc,
  input  wire logic [31:0] start_stack,
  output result_t          result
);
  localparam int RW = $clog2(REGISTER_COUNT);

  logic [31:0] regs_r [REGISTER_COUNT];
  logic [31:0] pc_r;
  logic        lp_r;
  logic [4:0]  ld_r;
  logic [2:0]  lt_r;
  logic [RW-1:0] clr_r;

  logic [1:0]  kind_r;
  logic [31:0] ins_r, lv_r, tgt_r, a_r, b_r;

  // decode stage registers
  logic [3:0]  st_r;
  logic [31:0] res_r, npc_r, addr_r, sdata_r;
  logic        wb_r, rd_r, wr_r;
  logic [1:0]  size_r;
  logic        needdiv_r;
  logic [63:0] prod_r;
  logic [1:0]  mulk_r;
  logic        ismul_r;

  // divider
  logic [31:0] dq_r, drem_r, dd_r;
  logic [5:0]  dcnt_r;
  logic        dneg_r, dremop_r, dspecial_r;
  logic [31:0] dspec_val_r;

  wire [6:0] op  = ins_r[6:0];
  wire [4:0] rd  = ins_r[11:7];
  wire [2:0] f3  = ins_r[14:12];
  wire [4:0] rs1 = ins_r[19:15];
  wire [4:0] rs2 = ins_r[24:20];
  wire [6:0] f7  = ins_r[31:25];

  function automatic logic [31:0] rget(input logic [4:0] i, input logic [31:0] v);
    rget = (i == 5'd0 || 32'(i) >= REGISTER_COUNT) ? 32'd0 : v;
  endfunction

  function automatic logic [31:0] rd_reg(input logic [4:0] i,
                                         input logic [31:0] rf [REGISTER_COUNT]);
    logic [31:0] v;
    v = 32'd0;
    for (int k = 0; k < REGISTER_COUNT; k++) if (32'(i) == k) v = rf[k];
    rd_reg = v;
  endfunction

  // decode combinational
  logic [31:0] immI, immS, immB, immJ, d_res, d_npc, d_addr, d_sdata, ib;
  logic [3:0]  d_st;
  logic        d_wb, d_rd, d_wr, d_div, d_mul, taken, uses_rd, uses_rs1, uses_rs2;
  logic [1:0]  d_size, d_mulk;
  logic [32:0] mend;
  logic [4:0]  sh;
  logic        in_text_pc, in_text_tgt, in_text_addr;

  always_comb begin
    immI = {{20{ins_r[31]}}, ins_r[31:20]};
    immS = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    immB = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    immJ = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    d_res = 32'd0; d_npc = pc_r + 32'd4; d_addr = 32'd0; d_sdata = 32'd0;
    d_st = ST_OK; d_wb = 1'b0; d_rd = 1'b0; d_wr = 1'b0; d_div = 1'b0; d_mul = 1'b0;
    d_size = 2'd0; d_mulk = 2'd0; taken = 1'b0;
    uses_rd = 1'b0; uses_rs1 = 1'b0; uses_rs2 = 1'b0;
    in_text_pc = (pc_r >= text_start) && (pc_r < text_end);
    ib = (op == OP_REG) ? b_r : immI;
    sh = ib[4:0];
    d_addr = a_r + ((op == OP_STORE) ? immS : immI);
    in_text_addr = (d_addr >= text_start) && (d_addr < text_end);
    d_size = f3[1:0];
    mend = {1'b0, d_addr} + (33'd1 << d_size);
    unique case (op)
      OP_REG: begin uses_rd = 1'b1; uses_rs1 = 1'b1; uses_rs2 = 1'b1; end
      OP_IMM, OP_LOAD, OP_JALR: begin uses_rd = 1'b1; uses_rs1 = 1'b1; end
      OP_STORE, OP_BRANCH: begin uses_rs1 = 1'b1; uses_rs2 = 1'b1; end
      default: ;
    endcase
    if (op == OP_LUI || op == OP_AUIPC || op == OP_JAL) uses_rd = 1'b1;
    if (op == OP_REG) begin
      priority if (f7 == 7'h00 || f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
        d_wb = 1'b1;
        unique case (f3)
          3'd0: d_res = f7[5] ? a_r - b_r : a_r + b_r;
          3'd1: d_res = a_r << sh;
          3'd2: d_res = {31'd0, $signed(a_r) < $signed(b_r)};
          3'd3: d_res = {31'd0, a_r < b_r};
          3'd4: d_res = a_r ^ b_r;
          3'd5: d_res = f7[5] ? 32'($signed(a_r) >>> sh) : a_r >> sh;
          3'd6: d_res = a_r | b_r;
          default: d_res = a_r & b_r;
        endcase
      end else if (f7 == 7'h01) begin
        d_wb = 1'b1;
        if (f3[2]) d_div = 1'b1; else begin d_mul = 1'b1; d_mulk = f3[1:0]; end
      end else d_st = ST_BAD_FN;
    end else if (op == OP_IMM) begin
      d_wb = 1'b1;
      unique case (f3)
        3'd0: d_res = a_r + immI;
        3'd1: d_res = a_r << sh;
        3'd2: d_res = {31'd0, $signed(a_r) < $signed(immI)};
        3'd3: d_res = {31'd0, a_r < immI};
        3'd4: d_res = a_r ^ immI;
        3'd5: begin
          if (ins_r[31:25] == 7'h20) d_res = 32'($signed(a_r) >>> sh);
          else if (ins_r[31:25] == 7'h00) d_res = a_r >> sh;
          else d_st = ST_BAD_FN;
        end
        3'd6: d_res = a_r | immI;
        default: d_res = a_r & immI;
      endcase
    end else if (op == OP_LOAD) begin
      if (f3 == 3'd3 || f3 > 3'd5) d_st = ST_BAD_FN;
      else if (mend > {1'b0, memory_bytes}) d_st = ST_BEYOND;
      else if (in_text_addr) d_st = ST_TEXT;
      else d_rd = 1'b1;
    end else if (op == OP_STORE) begin
      if (f3 > 3'd2) d_st = ST_BAD_FN;
      else if (mend > {1'b0, memory_bytes}) d_st = ST_BEYOND;
      else if (in_text_addr) d_st = ST_TEXT;
      else d_wr = 1'b1;
      d_sdata = (f3 == 3'd0) ? {24'd0, b_r[7:0]} :
                (f3 == 3'd1) ? {16'd0, b_r[15:0]} : b_r;
    end else if (op == OP_BRANCH) begin
      unique case (f3)
        3'd0: taken = a_r == b_r;
        3'd1: taken = a_r != b_r;
        3'd4: taken = $signed(a_r) < $signed(b_r);
        3'd5: taken = !($signed(a_r) < $signed(b_r));
        3'd6: taken = a_r < b_r;
        3'd7: taken = a_r >= b_r;
        default: d_st = ST_BAD_FN;
      endcase
      if (taken) d_npc = pc_r + immB;
    end else if (op == OP_LUI) begin
      d_wb = 1'b1; d_res = {ins_r[31:12], 12'd0};
    end else if (op == OP_AUIPC) begin
      d_wb = 1'b1; d_res = pc_r + {ins_r[31:12], 12'd0};
    end else if (op == OP_JAL) begin
      d_wb = 1'b1; d_res = pc_r + 32'd4; d_npc = pc_r + immJ;
    end else if (op == OP_JALR) begin
      if (f3 != 3'd0) d_st = ST_BAD_FN;
      d_wb = 1'b1; d_res = pc_r + 32'd4; d_npc = (a_r + immI) & ~32'd1;
    end else if (op == OP_SYSTEM || op == OP_FENCE) begin
    end else d_st = ST_BAD_OP;
    if (d_st != ST_BAD_OP &&
        ((uses_rd && 32'(rd) >= REGISTER_COUNT) || (uses_rs1 && 32'(rs1) >= REGISTER_COUNT) ||
         (uses_rs2 && 32'(rs2) >= REGISTER_COUNT)))
      d_st = ST_BAD_OP;
    // request-level checks
    in_text_tgt = (tgt_r >= text_start) && (tgt_r < text_end);
    if (kind_r == KIND_EXEC) begin
      if (memory_bytes == 32'd0) d_st = ST_NOT_LOADED;
      else if (lp_r) d_st = ST_SEQ;
      else if (!in_text_pc) d_st = ST_PC_OUT;
    end else if (kind_r == KIND_LOAD) begin
      d_st = lp_r ? ST_OK : ST_SEQ;
    end else if (kind_r == KIND_JUMP) begin
      if (memory_bytes == 32'd0) d_st = ST_NOT_LOADED;
      else if (!in_text_tgt) d_st = ST_BAD_TARGET;
      else d_st = ST_OK;
    end else d_st = ST_OK;
    if (kind_r != KIND_EXEC || d_st != ST_OK) begin d_div = 1'b0; d_mul = 1'b0; end
    if (d_st != ST_OK) begin d_rd = 1'b0; d_wr = 1'b0; end
  end

  // load extension
  logic [31:0] lext;
  always_comb begin
    unique case (lt_r)
      3'd0: lext = {{24{lv_r[7]}}, lv_r[7:0]};
      3'd1: lext = {{16{lv_r[15]}}, lv_r[15:0]};
      3'd4: lext = {24'd0, lv_r[7:0]};
      3'd5: lext = {16'd0, lv_r[15:0]};
      default: lext = lv_r;
    endcase
  end

  // divider step
  logic [32:0] dtrial;
  assign dtrial = {drem_r, dq_r[31]} - {1'b0, dd_r};

  assign stat.need_div   = needdiv_r;
  assign stat.div_done   = (dcnt_r == 6'd0);
  assign stat.clear_done = (32'(clr_r) == REGISTER_COUNT - 1);
  assign stat.is_restart = (kind == KIND_RESTART);

  logic [31:0] mres, dres, fres, qv, rv;
  always_comb begin
    unique case (mulk_r)
      2'd0: mres = prod_r[31:0];
      2'd1: mres = prod_r[63:32] - (a_r[31] ? b_r : 32'd0) - (b_r[31] ? a_r : 32'd0);
      2'd2: mres = prod_r[63:32] - (a_r[31] ? b_r : 32'd0);
      default: mres = prod_r[63:32];
    endcase
    qv = dneg_r ? 32'd0 - dq_r : dq_r;
    rv = dneg_r ? 32'd0 - drem_r : drem_r;
    dres = dspecial_r ? dspec_val_r : (dremop_r ? rv : qv);
    fres = ismul_r ? mres : (needdiv_r ? dres : res_r);
  end

  // result item formed from committed state
  result_t result_nxt;
  always_comb begin
    result_nxt = '0;
    result_nxt.status = st_r;
    if (kind_r == KIND_RESTART) begin
      result_nxt.next_pc = start_pc;
      result_nxt.writeback_valid = 1'b1;
      result_nxt.writeback_register = 5'd2;
      result_nxt.writeback_value = start_stack;
    end else if (kind_r == KIND_JUMP) begin
      result_nxt.next_pc = (st_r == ST_OK) ? tgt_r : pc_r;
    end else if (kind_r == KIND_LOAD) begin
      result_nxt.next_pc = pc_r;
      if (st_r == ST_OK && ld_r != 5'd0 && 32'(ld_r) < REGISTER_COUNT) begin
        result_nxt.writeback_valid = 1'b1;
        result_nxt.writeback_register = ld_r;
        result_nxt.writeback_value = lext;
      end
    end else begin
      result_nxt.next_pc = (st_r == ST_OK) ? npc_r : pc_r;
      if (st_r == ST_OK) begin
        result_nxt.mem_read = rd_r;
        result_nxt.mem_write = wr_r;
        if (rd_r || wr_r) begin
          result_nxt.mem_address = addr_r;
          result_nxt.access_size = size_r;
        end
        result_nxt.store_data = wr_r ? sdata_r : 32'd0;
        if (wb_r && rd != 5'd0) begin
          result_nxt.writeback_valid = 1'b1;
          result_nxt.writeback_register = rd;
          result_nxt.writeback_value = fres;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 32'd0; lp_r <= 1'b0; ld_r <= 5'd0; lt_r <= 3'd0;
      clr_r <= '0; needdiv_r <= 1'b0; ismul_r <= 1'b0; dcnt_r <= 6'd0;
      for (int k = 0; k < REGISTER_COUNT; k++) regs_r[k] <= 32'd0;
    end else begin
      if (cmd.latch) begin
        kind_r <= kind; ins_r <= instruction; lv_r <= load_value; tgt_r <= target_pc;
        a_r <= rget(instruction[19:15], rd_reg(instruction[19:15], regs_r));
        b_r <= rget(instruction[24:20], rd_reg(instruction[24:20], regs_r));
        clr_r <= '0;
      end
      if (cmd.clear_step) begin
        regs_r[clr_r] <= (32'(clr_r) == 2) ? start_stack : 32'd0;
        if (32'(clr_r) != REGISTER_COUNT - 1) clr_r <= clr_r + 1'b1;
      end
      if (cmd.decode) begin
        st_r <= d_st; res_r <= d_res; npc_r <= d_npc; addr_r <= d_addr;
        sdata_r <= d_sdata; wb_r <= d_wb; rd_r <= d_rd; wr_r <= d_wr; size_r <= d_size;
        needdiv_r <= d_div; ismul_r <= d_mul; mulk_r <= d_mulk;
        prod_r <= {32'd0, a_r} * {32'd0, b_r};
      end
      if (cmd.div_start) begin
        dremop_r <= f3[1];
        dspecial_r <= (b_r == 32'd0);
        dspec_val_r <= f3[1] ? a_r : 32'hFFFF_FFFF;
        if (!f3[0]) begin
          dq_r <= a_r[31] ? 32'd0 - a_r : a_r;
          dd_r <= b_r[31] ? 32'd0 - b_r : b_r;
          dneg_r <= f3[1] ? a_r[31] : (a_r[31] ^ b_r[31]);
        end else begin
          dq_r <= a_r; dd_r <= b_r; dneg_r <= 1'b0;
        end
        drem_r <= 32'd0; dcnt_r <= 6'd32;
      end
      if (cmd.div_step && dcnt_r != 6'd0) begin
        if (!dtrial[32]) begin
          drem_r <= dtrial[31:0]; dq_r <= {dq_r[30:0], 1'b1};
        end else begin
          drem_r <= {drem_r[30:0], dq_r[31]}; dq_r <= {dq_r[30:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.commit) begin
        result <= result_nxt;
        if (kind_r == KIND_RESTART) begin
          pc_r <= start_pc; lp_r <= 1'b0; ld_r <= 5'd0; lt_r <= 3'd0;
        end else if (kind_r == KIND_JUMP) begin
          if (st_r == ST_OK) pc_r <= tgt_r;
        end else if (kind_r == KIND_LOAD) begin
          if (st_r == ST_OK) begin
            lp_r <= 1'b0;
            if (ld_r != 5'd0 && 32'(ld_r) < REGISTER_COUNT) regs_r[ld_r[RW-1:0]] <= lext;
          end
        end else begin
          if (st_r == ST_OK) begin
            pc_r <= npc_r;
            if (rd_r) begin lp_r <= 1'b1; ld_r <= rd; lt_r <= f3; end
            if (wb_r && rd != 5'd0) regs_r[rd[RW-1:0]] <= fres;
          end
        end
      end
    end
  end

  `include "rv32im_instruction_execute_macros.svh"
  `RVX_ASSERT_IMP(a_div_count, dcnt_r != 6'd0, dcnt_r <= 6'd32, "divider count out of range")
  `RVX_ASSERT_NXT(a_div_start, cmd.div_start, dcnt_r == 6'd32, "divider did not load")
  `RVX_ASSERT_NXT(a_x0_wb, cmd.commit && kind_r == KIND_EXEC && rd == 5'd0,
                  !result.writeback_valid, "x0 writeback")
endmodule
`default_nettype wire

// File: rtl/rvx_control.sv
// Controller: sequences capture, decode, divide, restart clear, commit and output handshake
`timescale 1ns / 1ps
`default_nettype none
module rvx_control
  import rvx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV0, S_DIV, S_CLR, S_COMMIT, S_OUT} state_t;
  state_t state_r;
  logic   rst_req_r;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);

  always_comb begin
    cmd = '0;
    cmd.latch = in_valid && in_ready;
    cmd.decode = (state_r == S_DEC);
    cmd.div_start = (state_r == S_DIV0);
    cmd.div_step = (state_r == S_DIV);
    cmd.clear_step = (state_r == S_CLR);
    cmd.commit = (state_r == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0; rst_req_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_DEC; rst_req_r <= stat.is_restart;
        end
        S_DEC: state_r <= rst_req_r ? S_CLR : S_DIV0;
        S_DIV0: state_r <= stat.need_div ? S_DIV : S_COMMIT;
        S_DIV: if (stat.div_done) state_r <= S_COMMIT;
        S_CLR: if (stat.clear_done) state_r <= S_COMMIT;
        S_COMMIT: begin state_r <= S_OUT; out_valid <= 1'b1; end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (in_valid) begin
            state_r <= S_DEC; rst_req_r <= stat.is_restart;
          end else state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "rv32im_instruction_execute_macros.svh"
  `RVX_ASSERT_IMP(a_out_state, out_valid, state_r == S_OUT, "result valid outside output")
  `RVX_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.decode, cmd.div_start, cmd.div_step,
                  cmd.clear_step, cmd.commit}), "multiple commands")
  `RVX_ASSERT_NXT(a_commit_out, cmd.commit, out_valid, "commit without result")
endmodule
`default_nettype wire
